@@ design/bknn_pkg.sv @@
`timescale 1ns / 1ps

package bknn_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int VECTOR_BITS = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_NEIGHBOUR_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ENTRIES_IN_USE  = 2'd1;
    localparam logic [1:0] CFG_VOTE_THRESHOLD  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  entry_index;
        logic [3:0]  word_index;
        logic [63:0] word_data;
    } t_in;

    typedef struct packed {
        logic [3:0]  out_word_index;
        logic [63:0] resonance_word;
        logic [63:0] dissonance_word;
        logic        target_invalid;
        logic        last_word;
    } t_out;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_START     = 12'b000000000010,
        S_SCORE     = 12'b000000000100,
        S_SDRAIN    = 12'b000000001000,
        S_SELINIT   = 12'b000000010000,
        S_SELSCAN   = 12'b000000100000,
        S_SELWAIT   = 12'b000001000000,
        S_SELCOMMIT = 12'b000010000000,
        S_VINIT     = 12'b000100000000,
        S_VSCAN     = 12'b001000000000,
        S_VWAIT     = 12'b010000000000,
        S_VEMIT     = 12'b100000000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic score_issue;
        logic sel_init;
        logic sel_issue;
        logic sel_commit;
        logic vote_init;
        logic vote_issue;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic search;
        logic ent_last;
        logic wrd_last;
        logic score_busy;
        logic sel_found;
        logic round_last;
        logic out_free;
    } t_stat;

    function automatic logic [6:0] popcount64(input logic [63:0] x);
        logic [6:0] c;
        c = '0;
        for (int b = 0; b < 64; b++) begin
            c = c + 7'(x[b]);
        end
        return c;
    endfunction

endpackage

@@ design/bknn_ctrl.sv @@
`timescale 1ns / 1ps

module bknn_ctrl import bknn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_opcode,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic   o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_opcode == OP_QUERY) n_state = S_START;
            end
            S_START: begin
                n_state = i_stat.search ? S_SCORE : S_VINIT;
            end
            S_SCORE: begin
                o_cmd.score_issue = 1'b1;
                if (i_stat.ent_last && i_stat.wrd_last) n_state = S_SDRAIN;
            end
            S_SDRAIN: begin
                if (!i_stat.score_busy) n_state = S_SELINIT;
            end
            S_SELINIT: begin
                o_cmd.sel_init = 1'b1;
                n_state = S_SELSCAN;
            end
            S_SELSCAN: begin
                o_cmd.sel_issue = 1'b1;
                if (i_stat.ent_last) n_state = S_SELWAIT;
            end
            S_SELWAIT: begin
                n_state = S_SELCOMMIT;
            end
            S_SELCOMMIT: begin
                o_cmd.sel_commit = 1'b1;
                n_state = (!i_stat.sel_found || i_stat.round_last) ? S_VINIT : S_SELINIT;
            end
            S_VINIT: begin
                o_cmd.vote_init = 1'b1;
                n_state = S_VSCAN;
            end
            S_VSCAN: begin
                o_cmd.vote_issue = 1'b1;
                if (i_stat.ent_last) n_state = S_VWAIT;
            end
            S_VWAIT: begin
                n_state = S_VEMIT;
            end
            S_VEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_stat.wrd_last ? S_IDLE : S_VINIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/bknn_datapath.sv @@
`timescale 1ns / 1ps

module bknn_datapath import bknn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_in_data,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    localparam int VW = VECTOR_BITS / 64;
    localparam int WW = (VW > 1) ? $clog2(VW) : 1;
    localparam int EW = $clog2(NUM_ENTRIES);
    localparam int NW = $clog2(NUM_ENTRIES + 1);
    localparam int SW = $clog2(VECTOR_BITS + 1);
    localparam int AW = EW + WW;
    localparam int DEPTH = NUM_ENTRIES * (1 << WW);

    logic [5:0]  r_limit;
    logic [6:0]  r_inuse;
    logic [5:0]  r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 6'd1;
            r_inuse <= 7'd0;
            r_thr   <= 6'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NEIGHBOUR_LIMIT: r_limit <= i_cfg_data[5:0];
                CFG_ENTRIES_IN_USE:  r_inuse <= i_cfg_data;
                CFG_VOTE_THRESHOLD:  r_thr   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_used, nm1;
    logic [5:0]    keff;

    assign n_used = (32'(r_inuse) > NUM_ENTRIES) ? NW'(NUM_ENTRIES) : NW'(r_inuse);
    assign nm1    = (n_used == '0) ? '0 : n_used - NW'(1);
    assign keff   = (n_used <= NW'(1)) ? 6'd0 :
                    ((32'(r_limit) < 32'(nm1)) ? r_limit : 6'(nm1));

    logic [EW-1:0] r_target;
    logic          r_invalid;
    logic [EW-1:0] r_ent;
    logic [WW-1:0] r_wrd;
    logic [5:0]    r_round;
    logic [NUM_ENTRIES-1:0] r_chosen;
    logic          ent_last, wrd_last;
    logic          q_query;

    assign ent_last = (r_ent == EW'(nm1));
    assign wrd_last = (r_wrd == WW'(VW - 1));
    assign q_query  = i_cmd.accept && (i_in_data.opcode == OP_QUERY);

    logic [63:0] mem [DEPTH];
    logic [63:0] q_a, q_b;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    assign wr_en   = i_cmd.accept && (i_in_data.opcode == OP_WRITE) &&
                     (32'(i_in_data.entry_index) < NUM_ENTRIES) &&
                     (32'(i_in_data.word_index) < VW);
    assign wr_addr = {EW'(i_in_data.entry_index), WW'(i_in_data.word_index)};

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= i_in_data.word_data;
        q_a <= mem[{r_ent, r_wrd}];
        q_b <= mem[{r_target, r_wrd}];
    end

    // scoring pipeline
    logic          r_p1v, r_p1first, r_p1last;
    logic [EW-1:0] r_p1ent;
    logic          r_p2v, r_p2first, r_p2last;
    logic [EW-1:0] r_p2ent;
    logic [6:0]    r_pc;
    logic [SW-1:0] r_acc, acc_sum;

    logic [SW-1:0] smem [NUM_ENTRIES];
    logic [SW-1:0] r_sq;
    logic          r_sv;
    logic [EW-1:0] r_sj;
    logic [SW-1:0] r_best;
    logic [EW-1:0] r_bidx;
    logic          r_found;

    assign acc_sum = (r_p2first ? '0 : r_acc) + SW'(r_pc);

    always_ff @(posedge i_clk) begin
        if (r_p2v && r_p2last) smem[r_p2ent] <= acc_sum;
        r_sq <= smem[r_ent];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            r_p1v <= i_cmd.score_issue;
            r_p2v <= r_p1v;
            r_sv  <= i_cmd.sel_issue;
        end
        r_p1first <= (r_wrd == '0);
        r_p1last  <= wrd_last;
        r_p1ent   <= r_ent;
        r_p2first <= r_p1first;
        r_p2last  <= r_p1last;
        r_p2ent   <= r_p1ent;
        r_pc      <= popcount64(q_a & q_b);
        if (r_p2v) r_acc <= acc_sum;
        r_sj <= r_ent;
    end

    // vote stage
    logic          r_vv, r_vc;
    logic [5:0]    r_cnt [64];
    logic [63:0]   r_uni;
    logic [63:0]   res;

    always_comb begin
        for (int b = 0; b < 64; b++) begin
            res[b] = (r_cnt[b] > r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= 1'b0;
        end else begin
            r_vv <= i_cmd.vote_issue;
        end
        r_vc <= r_chosen[r_ent];
        if (i_cmd.vote_init) begin
            r_uni <= '0;
            for (int b = 0; b < 64; b++) r_cnt[b] <= '0;
        end else if (r_vv && r_vc) begin
            r_uni <= r_uni | q_a;
            for (int b = 0; b < 64; b++) r_cnt[b] <= r_cnt[b] + 6'(q_a[b]);
        end
    end

    // counters, selection and chosen set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen <= '0;
        end else if (q_query) begin
            r_chosen <= '0;
        end else if (i_cmd.sel_commit && r_found) begin
            r_chosen[r_bidx] <= 1'b1;
        end

        if (q_query) begin
            r_target  <= EW'(i_in_data.entry_index);
            r_invalid <= (32'(i_in_data.entry_index) >= 32'(n_used));
            r_ent     <= '0;
            r_wrd     <= '0;
            r_round   <= '0;
        end else if (i_cmd.score_issue) begin
            if (wrd_last) begin
                r_wrd <= '0;
                r_ent <= r_ent + EW'(1);
            end else begin
                r_wrd <= r_wrd + WW'(1);
            end
        end else if (i_cmd.sel_init || i_cmd.vote_init) begin
            r_ent <= '0;
        end else if (i_cmd.sel_issue || i_cmd.vote_issue) begin
            r_ent <= r_ent + EW'(1);
        end else if (i_cmd.emit) begin
            r_wrd <= wrd_last ? '0 : r_wrd + WW'(1);
        end

        if (i_cmd.sel_commit) r_round <= r_round + 6'd1;

        if (i_cmd.sel_init) begin
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (r_sv && r_sj != r_target && !r_chosen[r_sj] && r_sq > r_best) begin
            r_best  <= r_sq;
            r_bidx  <= r_sj;
            r_found <= 1'b1;
        end
    end

    // output register
    logic r_ov;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out.out_word_index  <= 4'(r_wrd);
            r_out.resonance_word  <= res;
            r_out.dissonance_word <= r_uni & ~res;
            r_out.target_invalid  <= r_invalid;
            r_out.last_word       <= wrd_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign o_stat.search     = !r_invalid && (keff != 6'd0);
    assign o_stat.ent_last   = ent_last;
    assign o_stat.wrd_last   = wrd_last;
    assign o_stat.score_busy = r_p1v || r_p2v;
    assign o_stat.sel_found  = r_found;
    assign o_stat.round_last = (r_round + 6'd1 == keff);
    assign o_stat.out_free   = !r_ov || !i_out_stall;

endmodule

@@ design/binary_knn_consensus_votes.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | i_in_valid/o_in_stall   | t_in (write word or query)
// out     | output    | o_out_valid/i_out_stall | t_out (one result word)
// cfg     | input     | i_cfg_valid/o_cfg_ready | index, 7-bit data
// A query scores the n entries in use (one stored word pair per cycle on
// the two read ports), ranks up to k neighbours (one score read per
// cycle) and votes the W words of the result, with n entries in use,
// W words per vector and k neighbours.
// Reset is synchronous, active low; the store holds no reset value.
// An output stall holds the result register and the next word waits.

module binary_knn_consensus_votes import bknn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    bknn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bknn_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
